// ===== sv/arp_pkg.sv =====
// Package for the ARM relocation patcher: relocation type codes, status codes
// and the packed item and result types shared by the modules.
// No dependencies.
`default_nettype none

package arp_pkg;

  // Relocation type codes, ELF ARM ABI numbering
  localparam logic [7:0] RT_NONE            = 8'd0;
  localparam logic [7:0] RT_ABS32           = 8'd2;
  localparam logic [7:0] RT_REL32           = 8'd3;
  localparam logic [7:0] RT_THM_CALL        = 8'd10;
  localparam logic [7:0] RT_GLOB_DAT        = 8'd21;
  localparam logic [7:0] RT_JUMP_SLOT       = 8'd22;
  localparam logic [7:0] RT_RELATIVE        = 8'd23;
  localparam logic [7:0] RT_CALL            = 8'd28;
  localparam logic [7:0] RT_JUMP24          = 8'd29;
  localparam logic [7:0] RT_THM_JUMP24      = 8'd30;
  localparam logic [7:0] RT_TARGET2         = 8'd41;
  localparam logic [7:0] RT_PREL31          = 8'd42;
  localparam logic [7:0] RT_MOVW_ABS_NC     = 8'd43;
  localparam logic [7:0] RT_MOVT_ABS        = 8'd44;
  localparam logic [7:0] RT_THM_MOVW_ABS_NC = 8'd47;
  localparam logic [7:0] RT_THM_MOVT_ABS    = 8'd48;
  localparam logic [7:0] RT_THM_PC12        = 8'd54;

  // Status codes
  localparam logic ST_OK          = 1'b0;
  localparam logic ST_UNSUPPORTED = 1'b1;

  // BLX opcode byte for an ARM call into Thumb code, H bit in bit 0
  localparam logic [6:0] ARM_BLX_TOP = 7'b1111101;

  typedef struct packed {
    logic [7:0]         kind;
    logic [31:0]        place_addr;
    logic [31:0]        insn_word;
    logic [31:0]        symbol_value;
    logic signed [31:0] explicit_addend;
    logic               target_is_thumb;
    logic               has_explicit_addend;
  } item_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic        status;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/arp_if.sv =====
// Valid/ready channel interfaces for the ARM relocation patcher: one for the
// relocation word coming in, one for the patched word going out. No dependencies.
`default_nettype none

interface arp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         kind;
  logic [31:0]        place_addr;
  logic [31:0]        insn_word;
  logic [31:0]        symbol_value;
  logic signed [31:0] explicit_addend;
  logic               target_is_thumb;
  logic               has_explicit_addend;

  modport source (
    output valid, kind, place_addr, insn_word, symbol_value, explicit_addend,
           target_is_thumb, has_explicit_addend,
    input  ready
  );
  modport sink (
    input  valid, kind, place_addr, insn_word, symbol_value, explicit_addend,
           target_is_thumb, has_explicit_addend,
    output ready
  );
endinterface

interface arp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] patched_word;
  logic        status;

  modport source (
    output valid, patched_word, status,
    input  ready
  );
  modport sink (
    input  valid, patched_word, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/arp_core.sv =====
// Combinational relocation datapath: addend decode, target and offset adds,
// and field packing of the patched word. Depends on arp_pkg.
`default_nettype none

module arp_core (
  input  arp_pkg::item_t   item,
  output arp_pkg::result_t res
);

  logic [15:0] hi;
  logic [15:0] lo;
  logic        tb_s;
  logic [31:0] add_thm_br;
  logic [31:0] add_arm_br;
  logic [31:0] add_thm_mov;
  logic [31:0] add_arm_mov;
  logic [31:0] addend;
  logic [31:0] sym_clr;
  logic [31:0] sum_sa;
  logic [31:0] sum_st;
  logic [31:0] sum_rel;
  logic        to_arm;
  logic [31:0] place_eff;
  logic [31:0] off;
  logic [23:0] br_r;
  logic        br_j1;
  logic        br_j2;
  logic [31:0] thm_branch;
  logic [15:0] movw_val;
  logic [15:0] movt_val;
  logic [15:0] mov_val;
  logic [31:0] arm_mov;
  logic [31:0] thm_mov;
  logic        is_movt;

  assign hi = item.insn_word[15:0];
  assign lo = item.insn_word[31:16];

  // Decode addends held in the instruction word
  assign tb_s       = hi[10];
  assign add_thm_br = {{7{tb_s}}, tb_s, ~(lo[13] ^ tb_s), ~(lo[11] ^ tb_s),
                       hi[9:0], lo[10:0], 1'b0};
  assign add_arm_br = {{6{item.insn_word[23]}}, item.insn_word[23:0],
                       (item.insn_word[31:28] == 4'hf) & item.insn_word[24], 1'b0};
  assign add_thm_mov = {16'd0, hi[3:0], hi[10], lo[14:12], lo[7:0]};
  assign add_arm_mov = {16'd0, item.insn_word[19:16], item.insn_word[11:0]};

  always_comb begin
    if (item.has_explicit_addend) begin
      addend = item.explicit_addend;
    end else begin
      case (item.kind)
        arp_pkg::RT_ABS32, arp_pkg::RT_GLOB_DAT, arp_pkg::RT_JUMP_SLOT,
        arp_pkg::RT_REL32:                          addend = item.insn_word;
        arp_pkg::RT_THM_CALL, arp_pkg::RT_THM_JUMP24: addend = add_thm_br;
        arp_pkg::RT_CALL, arp_pkg::RT_JUMP24:         addend = add_arm_br;
        arp_pkg::RT_THM_MOVW_ABS_NC, arp_pkg::RT_THM_MOVT_ABS:
                                                    addend = add_thm_mov;
        arp_pkg::RT_MOVW_ABS_NC, arp_pkg::RT_MOVT_ABS: addend = add_arm_mov;
        default:                                    addend = 32'd0;
      endcase
    end
  end

  assign sym_clr = {item.symbol_value[31:1], 1'b0};
  assign sum_sa  = sym_clr + addend;
  assign sum_st  = {sum_sa[31:1], sum_sa[0] | item.target_is_thumb};
  assign sum_rel = item.symbol_value + addend;

  // Thumb call into ARM code: word-align the place, BLX encoding
  assign to_arm    = !item.target_is_thumb && (item.kind == arp_pkg::RT_THM_CALL);
  assign place_eff = to_arm ? {item.place_addr[31:2], 2'b00} : item.place_addr;
  assign off       = sum_st - place_eff;

  assign br_r  = off[24:1];
  assign br_j1 = ~(br_r[22] ^ br_r[23]);
  assign br_j2 = ~(br_r[21] ^ br_r[23]);
  assign thm_branch = {lo[15], lo[14], br_j1, lo[12] & !to_arm, br_j2, br_r[10:0],
                       hi[15:11], br_r[23], br_r[20:11]};

  assign movw_val = sum_st[15:0];
  assign movt_val = sum_sa[31:16];
  assign is_movt  = (item.kind == arp_pkg::RT_MOVT_ABS) ||
                    (item.kind == arp_pkg::RT_THM_MOVT_ABS);
  assign mov_val  = is_movt ? movt_val : movw_val;
  assign arm_mov  = {item.insn_word[31:20], mov_val[15:12], item.insn_word[15:12],
                     mov_val[11:0]};
  assign thm_mov  = {lo[15], mov_val[10:8], lo[11:8], mov_val[7:0],
                     hi[15:11], mov_val[11], hi[9:4], mov_val[15:12]};

  always_comb begin
    res.patched_word = item.insn_word;
    res.status       = arp_pkg::ST_OK;
    case (item.kind)
      arp_pkg::RT_NONE, arp_pkg::RT_THM_PC12: begin
        res.patched_word = item.insn_word;
      end
      arp_pkg::RT_ABS32, arp_pkg::RT_GLOB_DAT, arp_pkg::RT_JUMP_SLOT,
      arp_pkg::RT_TARGET2: begin
        res.patched_word = sum_st;
      end
      arp_pkg::RT_RELATIVE: begin
        res.patched_word = sum_rel;
      end
      arp_pkg::RT_REL32: begin
        res.patched_word = off;
      end
      arp_pkg::RT_PREL31: begin
        res.patched_word = {item.insn_word[31], off[30:0]};
      end
      arp_pkg::RT_CALL, arp_pkg::RT_JUMP24: begin
        if (item.target_is_thumb && (item.kind == arp_pkg::RT_CALL)) begin
          res.patched_word = {arp_pkg::ARM_BLX_TOP, off[1], off[25:2]};
        end else begin
          res.patched_word = {item.insn_word[31:24], off[25:2]};
        end
      end
      arp_pkg::RT_THM_CALL, arp_pkg::RT_THM_JUMP24: begin
        res.patched_word = thm_branch;
      end
      arp_pkg::RT_MOVW_ABS_NC, arp_pkg::RT_MOVT_ABS: begin
        res.patched_word = arm_mov;
      end
      arp_pkg::RT_THM_MOVW_ABS_NC, arp_pkg::RT_THM_MOVT_ABS: begin
        res.patched_word = thm_mov;
      end
      default: begin
        res.status = arp_pkg::ST_UNSUPPORTED;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/arm_relocation_patcher.sv =====
// Top level of the ARM relocation patcher: input register, patch datapath,
// result register. Depends on arp_pkg, arp_if (arp_in_if, arp_out_if), arp_core.
`default_nettype none

// Channel   Dir  Word contents
// in_ch     in   kind, place_addr, insn_word, symbol_value, explicit_addend,
//                target_is_thumb, has_explicit_addend
// out_ch    out  patched_word, status
//
// One relocation word per cycle, back to back, while out_ch does not stall. A word
// passes through the input register and then the result register to out_ch.
// In the input register it goes through the decode, add, subtract and pack path of arp_core.
// Reset (rst_n low at a clock edge) empties both registers; no payload is cleared.
// A stalled result holds in place; the input register keeps filling until both
// registers are full, then in_ch.ready drops.

module arm_relocation_patcher (
  input  wire              clk,
  input  wire              rst_n,
  arp_in_if.sink           in_ch,
  arp_out_if.source        out_ch
);

  logic             s1_valid_r;
  arp_pkg::item_t   s1_item_r;
  logic             out_valid_r;
  arp_pkg::result_t out_res_r;
  arp_pkg::result_t core_res;
  logic             s2_adv;
  logic             s1_adv;

  // Advance the result register when it is empty or its word is taken
  assign s2_adv = !out_valid_r || out_ch.ready;
  // Advance the input register when it is empty or its word moves on
  assign s1_adv = !s1_valid_r || s2_adv;

  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_item_r.kind                <= in_ch.kind;
      s1_item_r.place_addr          <= in_ch.place_addr;
      s1_item_r.insn_word           <= in_ch.insn_word;
      s1_item_r.symbol_value        <= in_ch.symbol_value;
      s1_item_r.explicit_addend     <= in_ch.explicit_addend;
      s1_item_r.target_is_thumb     <= in_ch.target_is_thumb;
      s1_item_r.has_explicit_addend <= in_ch.has_explicit_addend;
    end
  end

  arp_core u_core (
    .item (s1_item_r),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.patched_word = out_res_r.patched_word;
  assign out_ch.status       = out_res_r.status;

endmodule

`default_nettype wire
